// ===== sv/bads_pkg.sv =====
// shared types and constants for the battery arbitrage scheduler
package bads_pkg;

  localparam int MAX_SLOTS   = 48;
  localparam int MAX_LEVELS  = 64;
  localparam int VALUE_WIDTH = 48;
  localparam int PRICE_WIDTH = 16;
  localparam int SLOT_W      = 6;
  localparam int LEVEL_W     = 6;
  localparam int NCNT_W      = 7;

  localparam logic [2:0] REG_LEVELS = 3'd0;
  localparam logic [2:0] REG_UP     = 3'd1;
  localparam logic [2:0] REG_DOWN   = 3'd2;
  localparam logic [2:0] REG_ENDMIN = 3'd3;
  localparam logic [2:0] REG_START  = 3'd4;
  localparam logic [2:0] REG_BUY    = 3'd5;
  localparam logic [2:0] REG_SELL   = 3'd6;
  localparam logic [2:0] REG_WEAR   = 3'd7;

  localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [PRICE_WIDTH-1:0] price;
    logic                          last_slot;
  } in_item_t;

  typedef struct packed {
    logic [5:0]                     slot_index;
    logic [5:0]                     soc_level;
    logic [5:0]                     charge_levels;
    logic [5:0]                     discharge_levels;
    logic [21:0]                    buy_energy;
    logic [21:0]                    sell_energy;
    logic signed [47:0]             slot_gain;
    logic signed [47:0]             profit_so_far;
    logic                           held_no_path;
    logic                           last_result;
  } out_item_t;

  // saturating add of two value words
  function automatic logic signed [VALUE_WIDTH-1:0] sat_add(
    input logic signed [VALUE_WIDTH-1:0] a,
    input logic signed [VALUE_WIDTH-1:0] b);
    logic signed [VALUE_WIDTH:0] s;
    begin
      s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
      if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1])
        sat_add = s[VALUE_WIDTH] ? VMIN : VMAX;
      else
        sat_add = s[VALUE_WIDTH-1:0];
    end
  endfunction

endpackage

// ===== sv/bads_cell.sv =====
// one level cell: holds a continuation value, scores a candidate per cycle
module bads_cell import bads_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,        // load initial value
  input  logic signed [VALUE_WIDTH-1:0] load_val,
  input  logic                          load_feas,
  input  logic                          clr,         // start a new slot scan
  input  logic                          cand_en,     // candidate beat present
  input  logic signed [VALUE_WIDTH-1:0] cand_val,    // reward plus next value
  input  logic [LEVEL_W-1:0]            cand_lvl,
  input  logic                          commit,      // end of slot: best becomes value
  input  logic                          shift_en,    // pass value along the row
  input  logic signed [VALUE_WIDTH-1:0] shin_val,
  input  logic                          shin_feas,
  output logic signed [VALUE_WIDTH-1:0] val,
  output logic                          feas,
  output logic [LEVEL_W-1:0]            best_lvl,
  output logic                          found
);

  logic signed [VALUE_WIDTH-1:0] val_r, best_r;
  logic                          feas_r, found_r;
  logic [LEVEL_W-1:0]            bn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feas_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      if (load) begin
        val_r  <= load_val;
        feas_r <= load_feas;
      end else if (commit) begin
        val_r  <= best_r;
        feas_r <= found_r;
      end else if (shift_en) begin
        val_r  <= shin_val;
        feas_r <= shin_feas;
      end
      if (clr) begin
        found_r <= 1'b0;
        best_r  <= '0;
        bn_r    <= '0;
      end else if (cand_en && (!found_r || cand_val > best_r)) begin
        found_r <= 1'b1;
        best_r  <= cand_val;
        bn_r    <= cand_lvl;
      end
    end
  end

  assign val      = val_r;
  assign feas     = feas_r;
  assign best_lvl = bn_r;
  assign found    = found_r;

endmodule

// ===== sv/bads_reward.sv =====
// reward of a move between two levels at one price, registered
module bads_reward import bads_pkg::*; (
  input  logic                          clk,
  input  logic [LEVEL_W-1:0]            from_lvl,
  input  logic [LEVEL_W-1:0]            to_lvl,
  input  logic signed [PRICE_WIDTH-1:0] price,
  input  logic [15:0]                   buy_pl,
  input  logic [15:0]                   sell_pl,
  input  logic [15:0]                   wear_pl,
  output logic [LEVEL_W-1:0]            chg,
  output logic [LEVEL_W-1:0]            dis,
  output logic [21:0]                   buy,
  output logic [21:0]                   sell,
  output logic signed [VALUE_WIDTH-1:0] reward
);

  logic [LEVEL_W-1:0]            chg_c, dis_c, chg_r, dis_r;
  logic [21:0]                   buy_r, sell_r, wear_r;
  logic signed [PRICE_WIDTH-1:0] price_r;
  logic signed [PRICE_WIDTH+23:0] prod;
  logic signed [VALUE_WIDTH-1:0] pv;

  always_comb begin
    chg_c = (to_lvl > from_lvl) ? to_lvl - from_lvl : '0;
    dis_c = (to_lvl < from_lvl) ? from_lvl - to_lvl : '0;
  end

  // stage one: energy amounts
  always_ff @(posedge clk) begin
    chg_r   <= chg_c;
    dis_r   <= dis_c;
    buy_r   <= 22'(chg_c) * 22'(buy_pl);
    sell_r  <= 22'(dis_c) * 22'(sell_pl);
    wear_r  <= 22'(7'(chg_c) + 7'(dis_c)) * 22'(wear_pl);
    price_r <= price;
  end

  // product fits 40 bits, no saturation needed at 48
  always_comb begin
    prod = price_r * $signed({2'b0, (sell_r != '0) ? sell_r : buy_r});
    if (buy_r != '0) prod = -prod;
    pv = VALUE_WIDTH'(prod);
  end

  always_ff @(posedge clk) begin
    chg    <= chg_r;
    dis    <= dis_r;
    buy    <= buy_r;
    sell   <= sell_r;
    reward <= sat_add(pv, -$signed({{(VALUE_WIDTH-22){1'b0}}, wear_r}));
  end

endmodule

// ===== sv/battery_arbitrage_dp_scheduler.sv =====
// top level: price store, cell row, decision tables and forward walk
//  channel | ports                        | carries
//  in      | in_valid in_ready in_data    | price, last_slot
//  out     | out_valid out_ready out_data | one result per stored slot
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data | register writes
// solve: load the row, then for each slot and source level rotate every next
// level past cell 0, drain the reward pipe and write the decision, plus one
// commit per slot; then the forward walk reads decision and price and runs
// the reward pipe for each result beat
// rst_n synchronous; the price and decision stores need no clearing
// input is held off while a horizon is solved or emitted; out stalls hold
module battery_arbitrage_dp_scheduler import bads_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0, ST_INIT = 3'd1, ST_SCAN = 3'd2,
                         ST_WB = 3'd3, ST_FWD = 3'd4, ST_FWD2 = 3'd5,
                         ST_OUT = 3'd6;

  logic [6:0]  lvl_r;
  logic [5:0]  up_r, dn_r, emin_r, start_r;
  logic [15:0] buy_r, sell_r, wear_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= 7'd64; up_r <= 6'd63; dn_r <= 6'd63; emin_r <= '0;
      start_r <= '0; buy_r <= 16'd256; sell_r <= 16'd256; wear_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LEVELS: lvl_r   <= cfg_data[6:0];
        REG_UP:     up_r    <= cfg_data[5:0];
        REG_DOWN:   dn_r    <= cfg_data[5:0];
        REG_ENDMIN: emin_r  <= cfg_data[5:0];
        REG_START:  start_r <= cfg_data[5:0];
        REG_BUY:    buy_r   <= cfg_data;
        REG_SELL:   sell_r  <= cfg_data;
        REG_WEAR:   wear_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [2:0]  st_r;
  logic [5:0]  cnt_r;      // stored slots
  logic [5:0]  T_r, t_r;
  logic [6:0]  n_r;
  logic [5:0]  s_r;        // source level under scan
  logic [6:0]  k_r;        // scan cycle within source level
  logic [5:0]  cur_r;
  logic signed [VALUE_WIDTH-1:0] profit_r;
  logic        held_r;
  logic [5:0]  nxt_r;

  // price store
  logic signed [PRICE_WIDTH-1:0] pmem [MAX_SLOTS];
  logic signed [PRICE_WIDTH-1:0] prd_r;
  logic [5:0]  prd_a;

  // decision store, address {slot, level}
  logic [6:0]  dmem [MAX_SLOTS*MAX_LEVELS];
  logic [6:0]  drd_r;
  logic        dwe;
  logic [11:0] dwa, dra;
  logic [6:0]  dwd;

  assign in_ready = (st_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && cnt_r < 6'(MAX_SLOTS))
      pmem[cnt_r] <= in_data.price;
    prd_r <= pmem[prd_a];
    if (dwe) dmem[dwa] <= dwd;
    drd_r <= dmem[dra];
  end

  // cell row: cell j holds value for next level j
  logic signed [VALUE_WIDTH-1:0] cval [MAX_LEVELS];
  logic                          cfeas [MAX_LEVELS];
  logic [LEVEL_W-1:0]            cbl  [MAX_LEVELS];
  logic                          cfnd [MAX_LEVELS];

  // scan: reward unit fed with (s, s2=k), its registered result lined up with
  // s2_d2; source s is scored in cell s while s2 sweeps past cell 0
  logic [5:0]  s2_d1, s2_d2;
  logic        v_d1, v_d2;
  logic [LEVEL_W-1:0] r_chg, r_dis;
  logic [21:0] r_buy, r_sell;
  logic signed [VALUE_WIDTH-1:0] r_rew;
  logic [5:0]  rf_from, rf_to;

  // value of next level s2: read by rotating the row so cell 0 holds s2
  logic signed [VALUE_WIDTH-1:0] nv_d1, nv_d2;
  logic        nf_d1, nf_d2;

  assign rf_from = (st_r == ST_SCAN) ? s_r : cur_r;
  assign rf_to   = (st_r == ST_SCAN) ? k_r[5:0] : nxt_r;

  bads_reward u_rew (
    .clk(clk), .from_lvl(rf_from), .to_lvl(rf_to), .price(prd_r),
    .buy_pl(buy_r), .sell_pl(sell_r), .wear_pl(wear_r),
    .chg(r_chg), .dis(r_dis), .buy(r_buy), .sell(r_sell), .reward(r_rew)
  );

  logic [6:0] hi_c;
  logic [6:0] lo_c;
  logic       inwin;
  always_comb begin
    lo_c = ({1'b0, s_r} > {1'b0, dn_r}) ? 7'({1'b0, s_r} - {1'b0, dn_r}) : 7'd0;
    hi_c = 7'({1'b0, s_r} + {1'b0, up_r});
    if (hi_c > n_r - 7'd1) hi_c = n_r - 7'd1;
    inwin = (k_r >= lo_c) && (k_r <= hi_c) && cfeas[0];
  end

  // the row rotates by one each scan cycle while k is below MAX_LEVELS; cell 0 then holds level k
  logic rot, cell_clr, commit, load;
  logic signed [VALUE_WIDTH-1:0] cand_v;
  assign cand_v = sat_add(r_rew, nv_d2);

  for (genvar j = 0; j < MAX_LEVELS; j++) begin : g_cell
    localparam int JN = (j + 1) % MAX_LEVELS;
    logic sel;
    assign sel = (s_r == 6'(j));
    bads_cell u_cell (
      .clk(clk), .rst_n(rst_n),
      .load(load), .load_val('0), .load_feas(6'(j) >= emin_r),
      .clr(cell_clr), .cand_en(sel && v_d2 && nf_d2 && st_r == ST_SCAN),
      .cand_val(cand_v), .cand_lvl(s2_d2),
      .commit(commit), .shift_en(rot),
      .shin_val(cval[JN]), .shin_feas(cfeas[JN]),
      .val(cval[j]), .feas(cfeas[j]), .best_lvl(cbl[j]), .found(cfnd[j])
    );
  end

  // rotation wraps at MAX_LEVELS; levels >= n are never in window
  assign rot = (st_r == ST_SCAN) && (k_r < 7'(MAX_LEVELS));

  always_ff @(posedge clk) begin
    s2_d1 <= k_r[5:0];  s2_d2 <= s2_d1;
    v_d1  <= (st_r == ST_SCAN) && (k_r < 7'(MAX_LEVELS)) && inwin;
    v_d2  <= v_d1;
    nv_d1 <= cval[0]; nv_d2 <= nv_d1;
    nf_d1 <= cfeas[0]; nf_d2 <= nf_d1;
  end

  // the best of every cell is cleared as it is committed, ready for the next slot
  assign load     = (st_r == ST_INIT);
  assign commit   = (st_r == ST_WB) && (s_r == n_r[5:0] - 6'd1 || n_r == 7'd64)
                    && k_r == 7'd127;
  assign cell_clr = (st_r == ST_INIT) || commit;

  // write decision for (t, s) at end of its scan
  assign dwe = (st_r == ST_WB) && k_r == 7'd0;
  assign dwa = {t_r, s_r};
  assign dwd = {~cfnd[s_r], cbl[s_r]};
  assign dra = {t_r, cur_r};
  // fetch the price of the next slot down during the commit cycle
  assign prd_a = (commit && t_r != '0) ? t_r - 6'd1 : t_r;

  out_item_t ob_r;
  logic      ov_r;
  assign out_valid = ov_r;
  assign out_data  = ob_r;

  logic [1:0] fw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; cnt_r <= '0; ov_r <= 1'b0;
    end else begin
      if (ov_r && out_ready && st_r != ST_OUT) ov_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: if (in_valid) begin
          if (in_data.last_slot) begin
            T_r  <= (cnt_r < 6'(MAX_SLOTS)) ? cnt_r + 6'd1 : cnt_r;
            t_r  <= (cnt_r < 6'(MAX_SLOTS)) ? cnt_r : cnt_r - 6'd1;
            n_r  <= (lvl_r < 7'd2) ? 7'd2 : (lvl_r > 7'd64) ? 7'd64 : lvl_r;
            cnt_r <= '0;
            st_r <= ST_INIT;
          end else if (cnt_r < 6'(MAX_SLOTS)) cnt_r <= cnt_r + 6'd1;
        end
        ST_INIT: begin
          s_r <= '0; k_r <= '0; st_r <= ST_SCAN;
        end
        ST_SCAN: begin
          // rotating through every level returns the row home, then the pipe drains
          if (k_r == 7'(MAX_LEVELS + 2)) begin
            k_r <= '0; st_r <= ST_WB;
          end else k_r <= k_r + 7'd1;
        end
        ST_WB: begin
          if (s_r == n_r[5:0] - 6'd1 || n_r == 7'd64 && s_r == 6'd63) begin
            if (k_r == 7'd127) begin
              if (t_r == '0) begin
                cur_r <= (start_r > n_r[5:0] - 6'd1 && n_r != 7'd64)
                         ? n_r[5:0] - 6'd1 : start_r;
                profit_r <= '0;
                st_r <= ST_FWD; fw_r <= '0;
              end else begin
                t_r <= t_r - 6'd1; s_r <= '0; k_r <= '0;
                st_r <= ST_SCAN;
              end
            end else k_r <= 7'd127;
          end else begin
            s_r <= s_r + 6'd1; k_r <= '0; st_r <= ST_SCAN;
          end
        end
        ST_FWD: begin
          // wait for decision and price reads
          fw_r <= fw_r + 2'd1;
          if (fw_r == 2'd1) begin
            held_r <= drd_r[6];
            nxt_r  <= drd_r[6] ? cur_r : drd_r[5:0];
            fw_r <= '0; st_r <= ST_FWD2;
          end
        end
        ST_FWD2: begin
          fw_r <= fw_r + 2'd1;
          if (fw_r == 2'd2) st_r <= ST_OUT;
        end
        ST_OUT: if (!ov_r || out_ready) begin
          ov_r <= 1'b1;
          ob_r.slot_index       <= t_r;
          ob_r.soc_level        <= nxt_r;
          ob_r.charge_levels    <= r_chg;
          ob_r.discharge_levels <= r_dis;
          ob_r.buy_energy       <= r_buy;
          ob_r.sell_energy      <= r_sell;
          ob_r.slot_gain        <= r_rew;
          ob_r.profit_so_far    <= sat_add(profit_r, r_rew);
          ob_r.held_no_path     <= held_r;
          ob_r.last_result      <= (t_r == T_r - 6'd1);
          profit_r <= sat_add(profit_r, r_rew);
          cur_r <= nxt_r;
          fw_r  <= '0;
          if (t_r == T_r - 6'd1) st_r <= ST_IDLE;
          else begin
            t_r <= t_r + 6'd1; st_r <= ST_FWD;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/bads_checker.sv =====
// checker: watches all three channels, predicts the schedule and compares result beats
module bads_checker import bads_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint V_HI = 64'sd140737488355327;
  localparam longint V_LO = -64'sd140737488355328;

  // register copies
  int     n_levels, up_lim, down_lim, end_min, start_lvl;
  longint buy_rate, sell_rate, wear_rate;

  longint    slot_price [MAX_SLOTS];
  int        n_stored;
  longint    future_val [2][MAX_LEVELS];
  bit        future_ok  [2][MAX_LEVELS];
  int        next_level [MAX_SLOTS][MAX_LEVELS];
  bit        stuck      [MAX_SLOTS][MAX_LEVELS];
  out_item_t schedule_q[$];

  function automatic longint clip(input longint a);
    if (a > V_HI) return V_HI;
    if (a < V_LO) return V_LO;
    return a;
  endfunction

  // operands stay within 48 bits, so the 64-bit sum cannot wrap
  function automatic longint sadd(input longint a, input longint b);
    return clip(a + b);
  endfunction

  function automatic longint move_gain(input int s, input int s2, input longint p,
                                       output int c, output int d,
                                       output longint b, output longint sl);
    longint r;
    c = 0; d = 0; b = 0; sl = 0; r = 0;
    if (s2 > s) begin
      c = s2 - s;
      b = c * buy_rate;
      r = -(p * b);
    end else if (s2 < s) begin
      d = s - s2;
      sl = d * sell_rate;
      r = p * sl;
    end
    return sadd(clip(r), -(wear_rate * (c + d)));
  endfunction

  task automatic solve_horizon();
    int n, horizon, row, nx, lo, hi, bn, cur, s2, c, d;
    longint best, v, b, sl, r, profit;
    bit found, held;
    out_item_t e;
    n = n_levels;
    if (n < 2) n = 2;
    if (n > MAX_LEVELS) n = MAX_LEVELS;
    horizon = n_stored;
    n_stored = 0;
    for (int s = 0; s < n; s++) begin
      future_val[horizon & 1][s] = 0;
      future_ok[horizon & 1][s] = (s >= end_min);
    end
    for (int t = horizon - 1; t >= 0; t--) begin
      row = t & 1;
      nx = (t + 1) & 1;
      for (int s = 0; s < n; s++) begin
        lo = s - down_lim;
        hi = s + up_lim;
        if (lo < 0) lo = 0;
        if (hi > n - 1) hi = n - 1;
        best = 0; bn = 0; found = 0;
        for (int k = lo; k <= hi; k++) begin
          if (!future_ok[nx][k]) continue;
          v = sadd(move_gain(s, k, slot_price[t], c, d, b, sl), future_val[nx][k]);
          // strict compare keeps the lowest level on ties
          if (!found || v > best) begin
            best = v; bn = k; found = 1;
          end
        end
        future_val[row][s] = best;
        future_ok[row][s] = found;
        next_level[t][s] = bn;
        stuck[t][s] = !found;
      end
    end
    cur = start_lvl;
    if (cur > n - 1) cur = n - 1;
    profit = 0;
    for (int t = 0; t < horizon; t++) begin
      held = stuck[t][cur];
      s2 = held ? cur : next_level[t][cur];
      r = move_gain(cur, s2, slot_price[t], c, d, b, sl);
      profit = sadd(profit, r);
      e.slot_index       = t[5:0];
      e.soc_level        = s2[5:0];
      e.charge_levels    = c[5:0];
      e.discharge_levels = d[5:0];
      e.buy_energy       = b[21:0];
      e.sell_energy      = sl[21:0];
      e.slot_gain        = r[47:0];
      e.profit_so_far    = profit[47:0];
      e.held_no_path     = held;
      e.last_result      = (t == horizon - 1);
      schedule_q.push_back(e);
      cur = s2;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    bit bad;
    if (!rst_n) begin
      n_levels = 64; up_lim = 63; down_lim = 63; end_min = 0; start_lvl = 0;
      buy_rate = 256; sell_rate = 256; wear_rate = 0;
      n_stored = 0;
      schedule_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LEVELS: n_levels  = cfg_data[6:0];
          REG_UP:     up_lim    = cfg_data[5:0];
          REG_DOWN:   down_lim  = cfg_data[5:0];
          REG_ENDMIN: end_min   = cfg_data[5:0];
          REG_START:  start_lvl = cfg_data[5:0];
          REG_BUY:    buy_rate  = cfg_data;
          REG_SELL:   sell_rate = cfg_data;
          REG_WEAR:   wear_rate = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        // store full: extra prices are dropped
        if (n_stored < MAX_SLOTS) begin
          slot_price[n_stored] = longint'(in_data.price);
          n_stored++;
        end
        if (in_data.last_slot) solve_horizon();
      end
      if (out_valid && out_ready) begin
        if (schedule_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat %p", out_data);
        end else begin
          want = schedule_q.pop_front();
          bad = (out_data.slot_index       !== want.slot_index)
             || (out_data.soc_level        !== want.soc_level)
             || (out_data.charge_levels    !== want.charge_levels)
             || (out_data.discharge_levels !== want.discharge_levels)
             || (out_data.buy_energy       !== want.buy_energy)
             || (out_data.sell_energy      !== want.sell_energy)
             || (out_data.slot_gain        !== want.slot_gain)
             || (out_data.profit_so_far    !== want.profit_so_far)
             || (out_data.held_no_path     !== want.held_no_path)
             || (out_data.last_result      !== want.last_result);
          if (bad) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p got %p", want, out_data);
          end
        end
      end
    end
    pending = schedule_q.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench top: clock, reset, stimulus with idling phases and the verdict
module tb_top;
  import bads_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 4000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid, in_ready;
  in_item_t    in_data;
  logic        out_valid, out_ready;
  out_item_t   out_data;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  int          fail_count, pending;

  int idle_mode;   // 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly
  int hold_left;
  int prices_sent;

  battery_arbitrage_dp_scheduler uut (.*);

  bads_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    longint cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // result side: long hold-off when asked, otherwise random stalls per phase
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else if (idle_mode == 2)
        out_ready = ($urandom_range(99) >= 63);
      else if (idle_mode == 3)
        out_ready = ($urandom_range(99) >= 14);
      else
        out_ready = 1'b1;
    end
  end

  function automatic bit sender_idle();
    if (idle_mode == 1) return $urandom_range(99) < 63;
    if (idle_mode == 3) return $urandom_range(99) < 14;
    return 0;
  endfunction

  task automatic send_price(input logic signed [15:0] p, input logic last);
    while (sender_idle()) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data = '{price: p, last_slot: last};
    do @(posedge clk); while (!in_ready);
    prices_sent++;
  endtask

  task automatic send_horizon(input int slots);
    logic signed [15:0] p;
    for (int i = 0; i < slots; i++) begin
      case ($urandom_range(7))
        0: p = 16'sh7fff;
        1: p = 16'sh8000;
        default: p = 16'($urandom());
      endcase
      send_price(p, i == slots - 1);
    end
  endtask

  // registers only change once the schedule has fully drained
  task automatic write_regs(input int n, input int up, input int dn, input int em,
                            input int st, input int b, input int s, input int w);
    logic [15:0] vals [8];
    logic [2:0]  idx  [8];
    vals = '{16'(n), 16'(up), 16'(dn), 16'(em), 16'(st), 16'(b), 16'(s), 16'(w)};
    idx  = '{REG_LEVELS, REG_UP, REG_DOWN, REG_ENDMIN, REG_START, REG_BUY, REG_SELL,
             REG_WEAR};
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_valid = 1'b1;
      cfg_index = idx[i];
      cfg_data = vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic int rate_pick();
    case ($urandom_range(5))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(65535);
    endcase
  endfunction

  initial begin
    int n, hz;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_LEVELS;
    cfg_data = '0;
    idle_mode = 0;
    hold_left = 0;
    prices_sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings, price extremes
    send_price(16'sh7fff, 1'b0);
    send_price(16'sh8000, 1'b1);
    // two levels, no movement allowed, zero rates
    write_regs(2, 0, 0, 0, 0, 0, 0, 0);
    send_price(16'sd5, 1'b0);
    send_price(-16'sd3, 1'b0);
    send_price(16'sd0, 1'b1);
    // level count below range clamps up, all rates at their top
    write_regs(0, 63, 63, 1, 63, 65535, 65535, 65535);
    send_price(16'sh8000, 1'b0);
    send_price(16'sh7fff, 1'b0);
    send_price(-16'sd1, 1'b1);
    // end minimum above the level count: nothing feasible
    write_regs(5, 2, 2, 7, 1, 256, 256, 3);
    send_price(16'sd100, 1'b0);
    send_price(-16'sd100, 1'b1);
    // level count above range clamps down, top level unreachable in time
    write_regs(127, 1, 1, 63, 0, 256, 256, 0);
    send_price(16'sd40, 1'b0);
    send_price(-16'sd7, 1'b1);
    // start level beyond the top level
    write_regs(6, 2, 3, 0, 40, 300, 200, 17);
    send_price(16'sd12, 1'b0);
    send_price(-16'sd30, 1'b0);
    send_price(16'sd9, 1'b0);
    send_price(16'sd50, 1'b1);

    hz = 0;
    while (prices_sent < 210) begin
      idle_mode = (hz / 3) % 4;
      n = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 9);
      write_regs(n, $urandom_range(n), $urandom_range(n),
                 ($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(n),
                 ($urandom_range(7) == 0) ? 63 : $urandom_range(n),
                 rate_pick(), rate_pick(), ($urandom_range(3) == 0) ? rate_pick() : 0);
      if (hz == 5) begin
        // receiver holds off past the solve while the next horizon keeps being offered
        hold_left = 5000;
        send_horizon(6);
        send_horizon(4);
      end else if (hz == 9) begin
        // store full: the surplus prices are dropped
        send_horizon(52);
      end else if (hz == 14) begin
        idle_mode = 0;
        write_regs(64, 63, 63, 0, 0, 65535, 65535, $urandom_range(65535));
        send_horizon(48);
      end else
        send_horizon($urandom_range(1, 8));
      hz++;
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bads_pkg.sv
sv/bads_cell.sv
sv/bads_reward.sv
sv/battery_arbitrage_dp_scheduler.sv
tb/sv/bads_checker.sv
tb/sv/tb_top.sv
